// ===== sv/lrcb_pkg.sv =====
// shared constants, codes and control structs for the line rasterizer
package lrcb_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int COORD_BITS_DEF  = 12;

    localparam int OP_W     = 2;
    localparam int CELL_W   = 16;
    localparam int WIDTH_W  = 8;
    localparam int HEIGHT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // command codes, code 3 does nothing
    localparam logic [OP_W-1:0] OP_PLOT = 2'd0;
    localparam logic [OP_W-1:0] OP_LINE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PEN_CHAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEN_ATTR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd3;

    localparam logic [CELL_W-1:0]   RESET_CHAR   = 16'd32;
    localparam logic [CELL_W-1:0]   WHITE        = 16'd15;
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 8'd10;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 7'd10;

    // point from the walker
    typedef struct packed {
        logic valid;
        logic last;
        logic rd;
    } t_pt_ctl;

    // memory request after clipping
    typedef struct packed {
        logic valid;
        logic we;
        logic in_area;
        logic last;
    } t_mem_ctl;

    // end of a command, seen at the store output
    typedef struct packed {
        logic valid;
        logic in_area;
    } t_done;

    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== sv/lrcb_walker.sv =====
// bresenham walker: emits one cell coordinate per cycle
module lrcb_walker #(
    parameter int COORD_BITS = lrcb_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_rd,
    input  logic signed [COORD_BITS-1:0] i_x1,
    input  logic signed [COORD_BITS-1:0] i_y1,
    input  logic signed [COORD_BITS-1:0] i_x2,
    input  logic signed [COORD_BITS-1:0] i_y2,
    output lrcb_pkg::t_pt_ctl            o_ctl,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    typedef enum logic [1:0] {S_IDLE, S_DIFF, S_INIT, S_RUN} t_state;
    typedef enum logic [1:0] {M_VERT, M_HORZ, M_XMAJ, M_YMAJ} t_mode;

    t_state r_state;
    t_mode  r_mode;
    logic   r_rd;
    logic signed [COORD_BITS-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [COORD_BITS-1:0] r_wx, r_wy, r_end, r_step;
    logic signed [EW-1:0] r_err, r_inc_a, r_inc_b;

    logic signed [DW-1:0] w_adx, w_ady;
    logic signed [EW-1:0] w_adx2, w_ady2;
    logic                 w_last;

    always_comb begin
        w_adx  = r_dx[DW-1] ? -r_dx : r_dx;
        w_ady  = r_dy[DW-1] ? -r_dy : r_dy;
        w_adx2 = EW'(w_adx) <<< 1;
        w_ady2 = EW'(w_ady) <<< 1;
        if (r_mode == M_VERT || r_mode == M_YMAJ) begin
            w_last = (r_wy == r_end);
        end else begin
            w_last = (r_wx == r_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x1    <= i_x1;
                        r_y1    <= i_y1;
                        r_x2    <= i_x2;
                        r_y2    <= i_y2;
                        r_rd    <= i_rd;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_dx    <= DW'(r_x2) - DW'(r_x1);
                    r_dy    <= DW'(r_y2) - DW'(r_y1);
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_step <= ((r_dx < 0) == (r_dy < 0)) ? COORD_BITS'(1) : '1;
                    if (r_dx == 0) begin
                        r_mode <= M_VERT;
                        r_wx   <= r_x1;
                        r_wy   <= (r_y1 < r_y2) ? r_y1 : r_y2;
                        r_end  <= (r_y1 < r_y2) ? r_y2 : r_y1;
                    end else if (r_dy == 0) begin
                        r_mode <= M_HORZ;
                        r_wy   <= r_y1;
                        r_wx   <= (r_x1 < r_x2) ? r_x1 : r_x2;
                        r_end  <= (r_x1 < r_x2) ? r_x2 : r_x1;
                    end else if (w_ady <= w_adx) begin
                        r_mode  <= M_XMAJ;
                        r_err   <= w_ady2 - EW'(w_adx);
                        r_inc_a <= w_ady2;
                        r_inc_b <= w_ady2 - w_adx2;
                        r_wx    <= r_dx[DW-1] ? r_x2 : r_x1;
                        r_wy    <= r_dx[DW-1] ? r_y2 : r_y1;
                        r_end   <= r_dx[DW-1] ? r_x1 : r_x2;
                    end else begin
                        r_mode  <= M_YMAJ;
                        r_err   <= w_adx2 - EW'(w_ady);
                        r_inc_a <= w_adx2;
                        r_inc_b <= w_adx2 - w_ady2;
                        r_wx    <= r_dy[DW-1] ? r_x2 : r_x1;
                        r_wy    <= r_dy[DW-1] ? r_y2 : r_y1;
                        r_end   <= r_dy[DW-1] ? r_y1 : r_y2;
                    end
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        case (r_mode)
                            M_VERT: r_wy <= r_wy + COORD_BITS'(1);
                            M_HORZ: r_wx <= r_wx + COORD_BITS'(1);
                            M_XMAJ: begin
                                r_wx <= r_wx + COORD_BITS'(1);
                                if (r_err < 0) begin
                                    r_err <= r_err + r_inc_a;
                                end else begin
                                    r_wy  <= r_wy + r_step;
                                    r_err <= r_err + r_inc_b;
                                end
                            end
                            default: begin
                                r_wy <= r_wy + COORD_BITS'(1);
                                if (r_err <= 0) begin
                                    r_err <= r_err + r_inc_a;
                                end else begin
                                    r_wx  <= r_wx + r_step;
                                    r_err <= r_err + r_inc_b;
                                end
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ctl.valid = (r_state == S_RUN);
    assign o_ctl.last  = w_last;
    assign o_ctl.rd    = r_rd;
    assign o_x         = r_wx;
    assign o_y         = r_wy;

endmodule

// ===== sv/lrcb_addr.sv =====
// clip against the active area and form the linear cell address
module lrcb_addr #(
    parameter int MAX_COLUMNS = lrcb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lrcb_pkg::MAX_ROWS_DEF,
    parameter int COORD_BITS  = lrcb_pkg::COORD_BITS_DEF,
    localparam int WW = $clog2(MAX_COLUMNS + 1),
    localparam int HW = $clog2(MAX_ROWS + 1),
    localparam int AW = lrcb_pkg::idx_bits(MAX_COLUMNS * MAX_ROWS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lrcb_pkg::t_pt_ctl            i_ctl,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic [WW-1:0]                i_eff_w,
    input  logic [HW-1:0]                i_eff_h,
    output lrcb_pkg::t_mem_ctl           o_ctl,
    output logic [AW-1:0]                o_addr
);

    localparam int XW   = lrcb_pkg::idx_bits(MAX_COLUMNS);
    localparam int YW   = lrcb_pkg::idx_bits(MAX_ROWS);
    localparam int DIMW = (WW > HW) ? WW : HW;
    localparam int CMPW = (COORD_BITS > DIMW) ? COORD_BITS : DIMW;
    localparam int PW   = YW + WW;

    logic [CMPW-1:0] w_ux, w_uy;
    logic            w_in_area;
    logic [PW-1:0]   w_prod;
    lrcb_pkg::t_mem_ctl r_ctl;
    logic [AW-1:0]   r_addr;

    always_comb begin
        w_ux      = CMPW'($unsigned(i_x));
        w_uy      = CMPW'($unsigned(i_y));
        w_in_area = !i_x[COORD_BITS-1] && (w_ux < CMPW'(i_eff_w)) &&
                    !i_y[COORD_BITS-1] && (w_uy < CMPW'(i_eff_h));
        w_prod    = PW'(w_uy[YW-1:0]) * PW'(i_eff_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid   <= i_ctl.valid;
            r_ctl.we      <= i_ctl.valid && !i_ctl.rd && w_in_area;
            r_ctl.in_area <= w_in_area;
            r_ctl.last    <= i_ctl.last;
        end
        r_addr <= AW'(w_prod) + AW'(w_ux[XW-1:0]);
    end

    assign o_ctl  = r_ctl;
    assign o_addr = r_addr;

endmodule

// ===== sv/lrcb_store.sv =====
// cell memory with clearing sweep after reset and registered read
module lrcb_store #(
    parameter int MAX_COLUMNS = lrcb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lrcb_pkg::MAX_ROWS_DEF,
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS,
    localparam int AW    = lrcb_pkg::idx_bits(DEPTH),
    localparam int DW    = 2 * lrcb_pkg::CELL_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrcb_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]      i_addr,
    input  logic [DW-1:0]      i_wdata,
    output logic               o_clearing,
    output lrcb_pkg::t_done    o_done,
    output logic [DW-1:0]      o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    lrcb_pkg::t_done r_done;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;

    always_comb begin
        w_we    = r_clearing || (i_ctl.valid && i_ctl.we);
        w_waddr = r_clearing ? r_clr_addr : i_addr;
        w_wdata = r_clearing ? '0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_ctl.valid) begin
            r_rdata <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_done     <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_done.valid   <= i_ctl.valid && i_ctl.last;
            r_done.in_area <= i_ctl.in_area;
        end
    end

    assign o_clearing = r_clearing;
    assign o_done     = r_done;
    assign o_rdata    = r_rdata;

endmodule

// ===== sv/line_rasterizer_to_cell_buffer.sv =====
// top level: character-cell frame store with bresenham line drawing
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------------
//  command  | in        | i_in_valid / o_in_stall  | i_operation, i_start_x/y, i_end_x/y
//  result   | out       | o_out_valid / i_out_stall| o_cell_char, o_cell_attr, o_in_range
//  config   | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// a plot or read walks a single cell; a line walks n cells where n is the cell
// count along its longest axis (up to 4096), one memory access per cycle; unused
// code 3 answers at once
// after reset the memory is swept to zero, one cell per cycle, over all
// MAX_COLUMNS*MAX_ROWS cells (8192 by default) with the command side stalled
// a stalled result waits in the output register; a second one parks and stalls
module line_rasterizer_to_cell_buffer #(
    parameter int MAX_COLUMNS = lrcb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = lrcb_pkg::MAX_ROWS_DEF,
    parameter int COORD_BITS  = lrcb_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lrcb_pkg::OP_W-1:0]            i_operation,
    input  logic signed [COORD_BITS-1:0]         i_start_x,
    input  logic signed [COORD_BITS-1:0]         i_start_y,
    input  logic signed [COORD_BITS-1:0]         i_end_x,
    input  logic signed [COORD_BITS-1:0]         i_end_y,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [lrcb_pkg::CELL_W-1:0]          o_cell_char,
    output logic [lrcb_pkg::CELL_W-1:0]          o_cell_attr,
    output logic                                 o_in_range,
    // configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lrcb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lrcb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int WW    = $clog2(MAX_COLUMNS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int AW    = lrcb_pkg::idx_bits(MAX_COLUMNS * MAX_ROWS);
    localparam int CW    = lrcb_pkg::CELL_W;

    typedef enum logic {T_IDLE, T_BUSY} t_state;

    // configuration registers
    logic [CW-1:0]                 r_pen_char, r_pen_attr;
    logic [lrcb_pkg::WIDTH_W-1:0]  r_active_width;
    logic [lrcb_pkg::HEIGHT_W-1:0] r_active_height;
    logic [WW-1:0]                 r_eff_w;
    logic [HW-1:0]                 r_eff_h;

    // control and result buffers
    t_state                      r_state;
    logic [lrcb_pkg::OP_W-1:0]   r_op;
    logic                        r_out_valid, r_pend_valid;
    logic [CW-1:0]               r_out_char, r_out_attr, r_pend_char, r_pend_attr;
    logic                        r_out_range, r_pend_range;

    // datapath between units
    lrcb_pkg::t_pt_ctl           pt_ctl;
    logic signed [COORD_BITS-1:0] pt_x, pt_y;
    lrcb_pkg::t_mem_ctl          mem_ctl;
    logic [AW-1:0]               mem_addr;
    lrcb_pkg::t_done             st_done;
    logic [2*CW-1:0]             st_rdata;
    logic                        st_clearing;

    logic                        w_accept, w_start, w_is_line;
    logic                        w_fin;
    logic [CW-1:0]               w_fin_char, w_fin_attr;
    logic                        w_fin_range;
    logic                        w_out_free;

    // command side is open only with the engine idle, no parked result and no clearing sweep
    assign o_in_stall  = (r_state != T_IDLE) || r_pend_valid || st_clearing;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_is_line   = (i_operation == lrcb_pkg::OP_LINE);

    // plot, line and read all go through the walker; plot and read as a
    // one-cell line, unused code 3 finishes at once with a zero result
    always_comb begin
        case (i_operation)
            lrcb_pkg::OP_PLOT, lrcb_pkg::OP_LINE, lrcb_pkg::OP_READ: w_start = w_accept;
            default:                                                 w_start = 1'b0;
        endcase
    end

    // finishing result: either an unused code right at accept or the store
    // reporting the last cell of the current request
    always_comb begin
        w_fin       = st_done.valid || (w_accept && !w_start);
        w_fin_char  = '0;
        w_fin_attr  = '0;
        w_fin_range = 1'b0;
        if (st_done.valid) begin
            case (r_op)
                lrcb_pkg::OP_READ: begin
                    if (st_done.in_area) begin
                        w_fin_char  = st_rdata[CW-1:0];
                        w_fin_attr  = st_rdata[2*CW-1:CW];
                        w_fin_range = 1'b1;
                    end
                end
                lrcb_pkg::OP_PLOT: w_fin_range = st_done.in_area;
                default:           w_fin_range = 1'b0;
            endcase
        end
        w_out_free = !r_out_valid || !i_out_stall;
    end

    // configuration registers and clamped active area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_char      <= lrcb_pkg::RESET_CHAR;
            r_pen_attr      <= lrcb_pkg::WHITE;
            r_active_width  <= lrcb_pkg::RESET_WIDTH;
            r_active_height <= lrcb_pkg::RESET_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lrcb_pkg::REG_PEN_CHAR: r_pen_char <= i_cfg_data;
                lrcb_pkg::REG_PEN_ATTR: r_pen_attr <= i_cfg_data;
                lrcb_pkg::REG_WIDTH:
                    r_active_width <= i_cfg_data[lrcb_pkg::WIDTH_W-1:0];
                lrcb_pkg::REG_HEIGHT:
                    r_active_height <= i_cfg_data[lrcb_pkg::HEIGHT_W-1:0];
                default: r_pen_char <= r_pen_char;
            endcase
        end
        r_eff_w <= (int'(r_active_width) > MAX_COLUMNS) ? WW'(MAX_COLUMNS)
                                                        : WW'(r_active_width);
        r_eff_h <= (int'(r_active_height) > MAX_ROWS) ? HW'(MAX_ROWS)
                                                      : HW'(r_active_height);
    end

    // request sequencing and the two-deep result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (w_start) begin
                        r_op    <= i_operation;
                        r_state <= T_BUSY;
                    end
                end
                T_BUSY: begin
                    if (st_done.valid) begin
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase

            if (w_out_free) begin
                if (r_pend_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_char   <= r_pend_char;
                    r_out_attr   <= r_pend_attr;
                    r_out_range  <= r_pend_range;
                    r_pend_valid <= 1'b0;
                end else if (w_fin) begin
                    r_out_valid <= 1'b1;
                    r_out_char  <= w_fin_char;
                    r_out_attr  <= w_fin_attr;
                    r_out_range <= w_fin_range;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_fin) begin
                r_pend_valid <= 1'b1;
                r_pend_char  <= w_fin_char;
                r_pend_attr  <= w_fin_attr;
                r_pend_range <= w_fin_range;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_char = r_out_char;
    assign o_cell_attr = r_out_attr;
    assign o_in_range  = r_out_range;

    lrcb_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_rd    (i_operation == lrcb_pkg::OP_READ),
        .i_x1    (i_start_x),
        .i_y1    (i_start_y),
        .i_x2    (w_is_line ? i_end_x : i_start_x),
        .i_y2    (w_is_line ? i_end_y : i_start_y),
        .o_ctl   (pt_ctl),
        .o_x     (pt_x),
        .o_y     (pt_y)
    );

    lrcb_addr #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .COORD_BITS  (COORD_BITS)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pt_ctl),
        .i_x     (pt_x),
        .i_y     (pt_y),
        .i_eff_w (r_eff_w),
        .i_eff_h (r_eff_h),
        .o_ctl   (mem_ctl),
        .o_addr  (mem_addr)
    );

    lrcb_store #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_addr     (mem_addr),
        .i_wdata    ({r_pen_attr, r_pen_char}),
        .o_clearing (st_clearing),
        .o_done     (st_done),
        .o_rdata    (st_rdata)
    );

    // store completion only ever belongs to a request in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_done.valid |-> (r_state == T_BUSY))
        else $error("store completion with no request in flight");

    // walker cells only appear while a request is in flight
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pt_ctl.valid |-> (r_state == T_BUSY))
        else $error("walker active with no request in flight");

    // a parked result always sits behind a full output register
    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("parked result with empty output register");

    // no memory request while the clearing sweep runs
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_clearing |-> !mem_ctl.valid)
        else $error("memory request during clearing sweep");

endmodule
